@@ rtl/core/rtc_counter_with_alarm_top_macros.svh @@
// ----------------------------------------------------------------------------
// RTC assertion macros
// Shared concurrent assertion forms for the real-time clock checker.
// ----------------------------------------------------------------------------
`ifndef RTC_COUNTER_WITH_ALARM_TOP_MACROS_SVH
`define RTC_COUNTER_WITH_ALARM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RCA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rca_pkg.sv @@
// ----------------------------------------------------------------------------
// RTC package
// Word types, command and register codes, and sizes for the real-time clock.
// ----------------------------------------------------------------------------
package rca_pkg;

  // Width of the prescaler reload and divider, 4 to 32.
  localparam int PRESC_W = 20;

  localparam logic [15:0] RELOAD_DEFAULT = 16'h7FFF;

  // Commands.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_CTRL_HI  = 3'd0;
  localparam logic [2:0] REG_CTRL_LO  = 3'd1;
  localparam logic [2:0] REG_PRESC_HI = 3'd2;
  localparam logic [2:0] REG_PRESC_LO = 3'd3;
  localparam logic [2:0] REG_CNT_HI   = 3'd4;
  localparam logic [2:0] REG_CNT_LO   = 3'd5;
  localparam logic [2:0] REG_ALRM_HI  = 3'd6;
  localparam logic [2:0] REG_ALRM_LO  = 3'd7;

  // Control register bit positions.
  localparam int BIT_ALRIE = 1;
  localparam int BIT_ALRF  = 1;
  localparam int BIT_RSF   = 3;
  localparam int BIT_CNF   = 4;
  localparam int BIT_RTOFF = 5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  reg_index;
    logic [15:0] write_data;
  } req_word_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        alarm_irq;
    logic        second_pulse;
  } rsp_word_t;

endpackage

@@ rtl/core/rtc_counter_with_alarm_top.sv @@
// ----------------------------------------------------------------------------
// RTC counter with alarm
// Prescaler, 32-bit seconds counter and alarm behind eight 16-bit registers.
// ----------------------------------------------------------------------------
// An accepted request word has its response word in the next cycle.
// Throughput: one request word per cycle unless a held response stalls input;
// the response register, the only stage, reloads in the same cycle it is taken.
// Reset (rst, synchronous, active high) clears the counter, loads the reload
// and divider with 0x7FFF, sets the alarm to all ones and empties the output.
module rtc_counter_with_alarm_top
  import rca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req_word,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp_word
);

  // Architectural state of the clock.
  logic [31:0]        seconds_count;
  logic [PRESC_W-1:0] prescaler_reload;
  logic [PRESC_W-1:0] prescaler_divider;
  logic [31:0]        alarm_value;
  logic               alarm_enable;
  logic               alarm_flag;
  logic               config_mode;
  logic               sync_flag;

  logic [31:0]        seconds_count_next;
  logic [PRESC_W-1:0] prescaler_reload_next;
  logic [PRESC_W-1:0] prescaler_divider_next;
  logic [31:0]        alarm_value_next;
  logic               alarm_enable_next;
  logic               alarm_flag_next;
  logic               config_mode_next;
  logic               sync_flag_next;

  logic               req_accept;
  logic [31:0]        reload_word;
  logic [31:0]        reload_word_next;
  logic [31:0]        seconds_inc;
  logic [15:0]        read_value;
  rsp_word_t          rsp_word_next;

  // A new request is taken unless a finished response is still held.
  assign req_stall  = rsp_valid & rsp_stall;
  assign req_accept = req_valid & ~req_stall;

  // The reload register is viewed as a 32-bit word for the half accesses.
  assign reload_word = 32'(prescaler_reload);
  assign seconds_inc = seconds_count + 32'd1;

  // Register read mux.
  always_comb begin
    read_value = '0;
    unique case (req_word.reg_index)
      REG_CTRL_HI: begin
        read_value[BIT_ALRIE] = alarm_enable;
      end
      REG_CTRL_LO: begin
        read_value[BIT_ALRF]  = alarm_flag;
        read_value[BIT_RSF]   = sync_flag;
        read_value[BIT_CNF]   = config_mode;
        read_value[BIT_RTOFF] = 1'b1;
      end
      REG_PRESC_HI: read_value = reload_word[31:16];
      REG_PRESC_LO: read_value = reload_word[15:0];
      REG_CNT_HI:   read_value = seconds_count[31:16];
      REG_CNT_LO:   read_value = seconds_count[15:0];
      REG_ALRM_HI:  read_value = alarm_value[31:16];
      REG_ALRM_LO:  read_value = alarm_value[15:0];
      default:      read_value = '0;
    endcase
  end

  // Next-state logic for one request word.
  always_comb begin
    seconds_count_next     = seconds_count;
    prescaler_reload_next  = prescaler_reload;
    prescaler_divider_next = prescaler_divider;
    alarm_value_next       = alarm_value;
    alarm_enable_next      = alarm_enable;
    alarm_flag_next        = alarm_flag;
    config_mode_next       = config_mode;
    sync_flag_next         = sync_flag;
    reload_word_next       = reload_word;
    rsp_word_next          = '0;

    case (req_word.cmd)
      CMD_TICK: begin
        // The divider reloads when it has already reached zero, and that
        // tick advances the seconds counter.
        sync_flag_next = 1'b1;
        if (prescaler_divider == '0) begin
          prescaler_divider_next     = prescaler_reload;
          seconds_count_next         = seconds_inc;
          rsp_word_next.second_pulse = 1'b1;
          if (seconds_inc == alarm_value) begin
            alarm_flag_next = 1'b1;
          end
        end else begin
          prescaler_divider_next = prescaler_divider - PRESC_W'(1);
        end
      end
      CMD_WRITE: begin
        unique case (req_word.reg_index)
          REG_CTRL_HI: begin
            alarm_enable_next = req_word.write_data[BIT_ALRIE];
          end
          REG_CTRL_LO: begin
            // Status flags clear on a written zero and hold on a one.
            if (!req_word.write_data[BIT_ALRF]) begin
              alarm_flag_next = 1'b0;
            end
            if (!req_word.write_data[BIT_RSF]) begin
              sync_flag_next = 1'b0;
            end
            config_mode_next = req_word.write_data[BIT_CNF];
          end
          REG_PRESC_HI: begin
            if (config_mode) begin
              reload_word_next      = {req_word.write_data, reload_word[15:0]};
              prescaler_reload_next = reload_word_next[PRESC_W-1:0];
            end
          end
          REG_PRESC_LO: begin
            if (config_mode) begin
              reload_word_next      = {reload_word[31:16], req_word.write_data};
              prescaler_reload_next = reload_word_next[PRESC_W-1:0];
            end
          end
          REG_CNT_HI: begin
            if (config_mode) begin
              seconds_count_next = {req_word.write_data, seconds_count[15:0]};
            end
          end
          REG_CNT_LO: begin
            if (config_mode) begin
              seconds_count_next = {seconds_count[31:16], req_word.write_data};
            end
          end
          REG_ALRM_HI: begin
            if (config_mode) begin
              alarm_value_next = {req_word.write_data, alarm_value[15:0]};
            end
          end
          REG_ALRM_LO: begin
            if (config_mode) begin
              alarm_value_next = {alarm_value[31:16], req_word.write_data};
            end
          end
          default: begin
          end
        endcase
      end
      CMD_READ: begin
        rsp_word_next.read_data = read_value;
      end
      default: begin
        // The unused command changes nothing.
      end
    endcase

    // The interrupt line reflects the state after this word.
    rsp_word_next.alarm_irq = alarm_flag_next & alarm_enable_next;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count     <= '0;
      prescaler_reload  <= PRESC_W'(RELOAD_DEFAULT);
      prescaler_divider <= PRESC_W'(RELOAD_DEFAULT);
      alarm_value       <= '1;
      alarm_enable      <= 1'b0;
      alarm_flag        <= 1'b0;
      config_mode       <= 1'b0;
      sync_flag         <= 1'b0;
    end else if (req_accept) begin
      seconds_count     <= seconds_count_next;
      prescaler_reload  <= prescaler_reload_next;
      prescaler_divider <= prescaler_divider_next;
      alarm_value       <= alarm_value_next;
      alarm_enable      <= alarm_enable_next;
      alarm_flag        <= alarm_flag_next;
      config_mode       <= config_mode_next;
      sync_flag         <= sync_flag_next;
    end
  end

  // Response register: fills on an accepted request, empties when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      rsp_word <= rsp_word_next;
    end
  end

endmodule

@@ rtl/core/rca_checker.sv @@
// ----------------------------------------------------------------------------
// RTC port checker
// Concurrent assertions on the handshake and response words of the RTC.
// ----------------------------------------------------------------------------
`include "rtc_counter_with_alarm_top_macros.svh"

module rca_checker
  import rca_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input req_word_t req_word,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_word_t rsp_word
);

  logic req_taken;
  logic rsp_taken;
  logic rsp_held;
  logic quiet_cmd;
  logic quiet_rsp;

  assign req_taken = req_valid & ~req_stall;
  assign rsp_taken = rsp_valid & ~rsp_stall;
  assign rsp_held  = rsp_valid & rsp_stall;

  // Writes and the unused command carry neither data nor a second pulse.
  assign quiet_cmd = req_taken & (req_word.cmd != CMD_TICK) & (req_word.cmd != CMD_READ);
  assign quiet_rsp = ~rsp_word.second_pulse & (rsp_word.read_data == 16'd0);

  // A stalled response stays put.
  `RCA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_held, rsp_valid && $stable(rsp_word), "word not held")

  // Every taken request yields a response in the next cycle.
  `RCA_ASSERT_NEXT(a_req_to_rsp, clk, rst, req_taken, rsp_valid, "request without response")

  // A taken response with no new request leaves the output empty.
  `RCA_ASSERT_NEXT(a_rsp_drain, clk, rst, rsp_taken && !req_taken, !rsp_valid, "response repeated")

  // Only a tick can report a second, and only a read returns data.
  `RCA_ASSERT_NEXT(a_quiet_fields, clk, rst, quiet_cmd, quiet_rsp, "stray data or pulse")

endmodule

bind rtc_counter_with_alarm_top rca_checker u_rca_checker (.*);
